// ===== rtl/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg
// Shared constants, widths and the arctangent table for the spherical warp
// coordinate map.
// ----------------------------------------------------------------------------
package swc_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int MARGIN_DEF  = 100;

	localparam int ITERS  = 16;
	localparam int VEC_W  = 28;   // vectoring datapath width
	localparam int ROT_W  = 20;   // rotation datapath width
	localparam int ANG_W  = 20;   // Q3.16 angle width
	localparam int DIM_W  = 13;
	localparam int FOC_W  = 14;
	localparam int CRD_W  = 12;
	localparam int RGB_W  = 24;
	localparam int DEL_W  = 14;   // centred coordinate width

	localparam logic [15:0] INV_K = 16'd39797;
	localparam int FIELD13_MAX = 8191;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FOCAL  = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0:       v = 20'sd51472;
			1:       v = 20'sd30385;
			2:       v = 20'sd16055;
			3:       v = 20'sd8150;
			4:       v = 20'sd4091;
			5:       v = 20'sd2047;
			6:       v = 20'sd1024;
			7:       v = 20'sd512;
			8:       v = 20'sd256;
			9:       v = 20'sd128;
			10:      v = 20'sd64;
			11:      v = 20'sd32;
			12:      v = 20'sd16;
			13:      v = 20'sd8;
			14:      v = 20'sd4;
			15:      v = 20'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/spherical_warp_coordinate_map_unit.sv =====
// ----------------------------------------------------------------------------
// spherical_warp_coordinate_map_unit
// Forward spherical warp of one source pixel per clock, unless the output stalls,
// through three chains of cordic cells.
// ----------------------------------------------------------------------------
// throughput: one pixel per clock, set by the fully pipelined cell chains
// (16 theta cells, 16 phi cells, 16 cosine cells, then the multiply stages)
// the whole pipe holds on output backpressure; dropped pixels leave a bubble
// reset: all valid flags clear, registers return to 640 x 480, focal 700
module spherical_warp_coordinate_map_unit import swc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int MARGIN  = MARGIN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [FOC_W-1:0] cfg_data,
	// source pixel channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CRD_W-1:0] src_col,
	input  logic [CRD_W-1:0] src_row,
	input  logic [RGB_W-1:0] pixel_rgb,
	// destination pixel channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DIM_W-1:0] dst_col,
	output logic [DIM_W-1:0] dst_row,
	output logic [RGB_W-1:0] out_rgb
);

	localparam int SA = 1 + DEL_W + RGB_W;   // zero flag, dy, rgb
	localparam int SB = 1 + ANG_W + RGB_W;   // zero flag, theta, rgb
	localparam int SC = 2 * ANG_W + RGB_W;   // theta, phi, rgb
	localparam int SUM_W = 56;
	localparam int ROW_W = 40;

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [FOC_W-1:0] focal_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			focal_q  <= 14'd700;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_FOCAL:  focal_q  <= cfg_data;
				REG_NONE:   ;
			endcase
		end
	end

	// clamp image size, derive output size and the scaled focal length
	logic [DIM_W:0] w_eff, h_eff, out_w, out_h;
	logic signed [VEC_W-1:0] f_x;

	always_comb begin
		w_eff = (int'(width_q) > MAX_DIM) ? (DIM_W+1)'(MAX_DIM) : {1'b0, width_q};
		h_eff = (int'(height_q) > MAX_DIM) ? (DIM_W+1)'(MAX_DIM) : {1'b0, height_q};
		out_w = w_eff + (DIM_W+1)'(MARGIN);
		out_h = h_eff + (DIM_W+1)'(MARGIN);
		f_x   = VEC_W'({focal_q, 8'd0});
	end

	// whole pipe advances unless the output holds an untaken result
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// centre the incoming pixel
	logic signed [DEL_W-1:0] dx, dy;
	assign dx = DEL_W'(src_col) - DEL_W'(w_eff >> 1);
	assign dy = DEL_W'(src_row) - DEL_W'(h_eff >> 1);

	// chain a: theta = atan2(dx, f), magnitude r
	logic                    va   [0:ITERS];
	logic signed [VEC_W-1:0] xa   [0:ITERS];
	logic signed [VEC_W-1:0] ya   [0:ITERS];
	logic signed [ANG_W-1:0] za   [0:ITERS];
	logic [SA-1:0]           sa   [0:ITERS];

	assign va[0] = in_valid;
	assign xa[0] = f_x;
	assign ya[0] = VEC_W'(dx) <<< 8;
	assign za[0] = '0;
	assign sa[0] = {dx == '0, dy, pixel_rgb};

	// chain b: phi = atan2(dy, r)
	logic                    vb   [0:ITERS];
	logic signed [VEC_W-1:0] xb   [0:ITERS];
	logic signed [VEC_W-1:0] yb   [0:ITERS];
	logic signed [ANG_W-1:0] zb   [0:ITERS];
	logic [SB-1:0]           sb   [0:ITERS];

	// chain c: cos(phi)
	logic                    vc   [0:ITERS];
	logic signed [ROT_W-1:0] xc   [0:ITERS];
	logic signed [ROT_W-1:0] yc   [0:ITERS];
	logic signed [ANG_W-1:0] zc   [0:ITERS];
	logic [SC-1:0]           sc   [0:ITERS];

	for (genvar i = 0; i < ITERS; i++) begin : g_cells
		swc_vec_cell #(.IDX(i), .SW(SA)) u_theta (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(va[i]), .x_in(xa[i]), .y_in(ya[i]), .z_in(za[i]), .side_in(sa[i]),
			.valid_q(va[i+1]), .x_q(xa[i+1]), .y_q(ya[i+1]), .z_q(za[i+1]),
			.side_q(sa[i+1])
		);
		swc_vec_cell #(.IDX(i), .SW(SB)) u_phi (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(vb[i]), .x_in(xb[i]), .y_in(yb[i]), .z_in(zb[i]), .side_in(sb[i]),
			.valid_q(vb[i+1]), .x_q(xb[i+1]), .y_q(yb[i+1]), .z_q(zb[i+1]),
			.side_q(sb[i+1])
		);
		swc_rot_cell #(.IDX(i), .SW(SC)) u_cos (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_in(vc[i]), .x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]), .side_in(sc[i]),
			.valid_q(vc[i+1]), .x_q(xc[i+1]), .y_q(yc[i+1]), .z_q(zc[i+1]),
			.side_q(sc[i+1])
		);
	end

	// magnitude scaling: r = floor(x * INV_K / 2^16), bypassed when dx is zero
	logic                    v_s1, v_s2;
	logic signed [44:0]      prod_s1;
	logic signed [ANG_W-1:0] theta_s1, theta_s2;
	logic                    zero_s1;
	logic signed [DEL_W-1:0] dy_s1, dy_s2;
	logic [RGB_W-1:0]        rgb_s1, rgb_s2;
	logic signed [VEC_W-1:0] r8_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= va[ITERS];
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= 45'(xa[ITERS]) * $signed({1'b0, INV_K});
			zero_s1  <= sa[ITERS][SA-1];
			theta_s1 <= sa[ITERS][SA-1] ? '0 : za[ITERS];
			dy_s1    <= sa[ITERS][RGB_W +: DEL_W];
			rgb_s1   <= sa[ITERS][RGB_W-1:0];

			r8_s2    <= zero_s1 ? f_x : prod_s1[16 +: VEC_W];
			theta_s2 <= theta_s1;
			dy_s2    <= dy_s1;
			rgb_s2   <= rgb_s1;
		end
	end

	assign vb[0] = v_s2;
	assign xb[0] = r8_s2;
	assign yb[0] = VEC_W'(dy_s2) <<< 8;
	assign zb[0] = '0;
	assign sb[0] = {dy_s2 == '0, theta_s2, rgb_s2};

	// phi feeds the cosine chain, zero when dy was zero
	logic signed [ANG_W-1:0] phi;
	assign phi = sb[ITERS][SB-1] ? '0 : zb[ITERS];

	assign vc[0] = vb[ITERS];
	assign xc[0] = ROT_W'($signed({1'b0, INV_K}));
	assign yc[0] = '0;
	assign zc[0] = phi;
	assign sc[0] = {sb[ITERS][RGB_W +: ANG_W], phi, sb[ITERS][RGB_W-1:0]};

	// destination arithmetic
	logic                    v_s3, v_s4;
	logic signed [39:0]      tc_s3;
	logic signed [ROW_W-1:0] fp_s3, rs_s4;
	logic [RGB_W-1:0]        rgb_s3, rgb_s4;
	logic signed [SUM_W-1:0] cs_s4;
	logic signed [FOC_W:0]   f_s;

	assign f_s = $signed({1'b0, focal_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vc[ITERS];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tc_s3  <= 40'($signed(sc[ITERS][RGB_W+ANG_W +: ANG_W])) * 40'(xc[ITERS]);
			fp_s3  <= ROW_W'($signed(sc[ITERS][RGB_W +: ANG_W])) * ROW_W'(f_s);
			rgb_s3 <= sc[ITERS][RGB_W-1:0];

			cs_s4  <= SUM_W'(tc_s3) * SUM_W'(f_s)
				+ (SUM_W'(out_w >> 1) <<< 32);
			rs_s4  <= fp_s3 + (ROW_W'(out_h >> 1) <<< 16);
			rgb_s4 <= rgb_s3;
		end
	end

	// truncation toward zero and output window check
	logic signed [SUM_W-33:0] dcol;
	logic signed [ROW_W-17:0] drow;
	logic                     keep;

	always_comb begin
		dcol = cs_s4[SUM_W-1] ? (SUM_W-32)'((cs_s4 + SUM_W'(33'h0_FFFF_FFFF)) >>> 32)
			: cs_s4[SUM_W-1:32];
		drow = rs_s4[ROW_W-1] ? (ROW_W-16)'((rs_s4 + ROW_W'(17'h0_FFFF)) >>> 16)
			: rs_s4[ROW_W-1:16];
		keep = !dcol[SUM_W-33] && (dcol < (SUM_W-32)'(out_w))
			&& (dcol <= (SUM_W-32)'(FIELD13_MAX))
			&& !drow[ROW_W-17] && (drow < (ROW_W-16)'(out_h))
			&& (drow <= (ROW_W-16)'(FIELD13_MAX));
	end

	// output register
	logic             out_valid_q;
	logic [DIM_W-1:0] dst_col_q, dst_row_q;
	logic [RGB_W-1:0] out_rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_col_q <= dcol[DIM_W-1:0];
			dst_row_q <= drow[DIM_W-1:0];
			out_rgb_q <= rgb_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign dst_col   = dst_col_q;
	assign dst_row   = dst_row_q;
	assign out_rgb   = out_rgb_q;

endmodule

// ===== rtl/swc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// swc_vec_cell
// One vectoring micro-rotation stage, drives y toward zero.
// ----------------------------------------------------------------------------
module swc_vec_cell import swc_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_in,
	input  logic signed [VEC_W-1:0] x_in,
	input  logic signed [VEC_W-1:0] y_in,
	input  logic signed [ANG_W-1:0] z_in,
	input  logic [SW-1:0]           side_in,
	output logic                    valid_q,
	output logic signed [VEC_W-1:0] x_q,
	output logic signed [VEC_W-1:0] y_q,
	output logic signed [ANG_W-1:0] z_q,
	output logic [SW-1:0]           side_q
);

	localparam logic signed [ANG_W-1:0] ANG = atan_q16(IDX);

	logic signed [VEC_W-1:0] xs, ys;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (!y_in[VEC_W-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ANG;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ANG;
			end
		end
	end

endmodule

// ===== rtl/swc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// swc_rot_cell
// One rotation micro-rotation stage, drives z toward zero.
// ----------------------------------------------------------------------------
module swc_rot_cell import swc_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_in,
	input  logic signed [ROT_W-1:0] x_in,
	input  logic signed [ROT_W-1:0] y_in,
	input  logic signed [ANG_W-1:0] z_in,
	input  logic [SW-1:0]           side_in,
	output logic                    valid_q,
	output logic signed [ROT_W-1:0] x_q,
	output logic signed [ROT_W-1:0] y_q,
	output logic signed [ANG_W-1:0] z_q,
	output logic [SW-1:0]           side_q
);

	localparam logic signed [ANG_W-1:0] ANG = atan_q16(IDX);

	logic signed [ROT_W-1:0] xs, ys;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (!z_in[ANG_W-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ANG;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ANG;
			end
		end
	end

endmodule

// ===== tb/spherical_warp_coordinate_map_unit_tb.sv =====
// ----------------------------------------------------------------------------
// spherical_warp_coordinate_map_unit_tb
// Drives source pixels through the warp unit under several image and focal
// settings, with random gaps on both channels, and checks every destination
// pixel against a fixed-point cordic predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
module spherical_warp_coordinate_map_unit_tb import swc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic [RGB_W-1:0] rgb;
	} dst_pixel_t;

	// warp predictor and store of pending destination pixels
	class warp_scoreboard;
		dst_pixel_t pending[$];
		int unsigned fails;
		longint img_w, img_h, focal;
		longint atan_tab[16];

		function new();
			atan_tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
				256, 128, 64, 32, 16, 8, 4, 2};
			img_w = 640;
			img_h = 480;
			focal = 700;
			fails = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [FOC_W-1:0] data);
			case (idx)
				REG_WIDTH:  img_w = longint'(data[DIM_W-1:0]);
				REG_HEIGHT: img_h = longint'(data[DIM_W-1:0]);
				REG_FOCAL:  focal = longint'(data);
				default: ;
			endcase
		endfunction

		// vectoring run: angle of (x, y), magnitude through mag
		function longint vector_angle(longint x, longint y, output longint mag);
			longint z, xs, ys;
			z = 0;
			if (y == 0) begin
				mag = x;
				return 0;
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_tab[i];
				end else begin
					x -= ys; y += xs; z -= atan_tab[i];
				end
			end
			mag = (x * 39797) >>> 16;
			return z;
		endfunction

		function longint rotate_cos(longint z);
			longint x, y, xs, ys;
			x = 39797;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_tab[i];
				end else begin
					x += ys; y -= xs; z += atan_tab[i];
				end
			end
			return x;
		endfunction

		function longint trunc_shift(longint v, int s);
			if (v >= 0)
				return v >>> s;
			return -((-v) >>> s);
		endfunction

		function void note_pixel(logic [CRD_W-1:0] col, logic [CRD_W-1:0] row,
				logic [RGB_W-1:0] rgb);
			longint w, h, dx, dy, r8, spare, theta, phi, cosq, s, dcol, drow;
			dst_pixel_t p;
			w = (img_w > 4096) ? 4096 : img_w;
			h = (img_h > 4096) ? 4096 : img_h;
			dx = longint'(col) - w / 2;
			dy = longint'(row) - h / 2;
			theta = vector_angle(focal * 256, dx * 256, r8);
			phi = vector_angle(r8, dy * 256, spare);
			cosq = rotate_cos(phi);
			s = focal * theta * cosq + ((w + 100) / 2) * 64'sd4294967296;
			dcol = trunc_shift(s, 32);
			s = focal * phi + ((h + 100) / 2) * 65536;
			drow = trunc_shift(s, 16);
			// destinations off the output image are dropped
			if (dcol < 0 || dcol >= w + 100 || dcol > 8191)
				return;
			if (drow < 0 || drow >= h + 100 || drow > 8191)
				return;
			p.col = dcol[DIM_W-1:0];
			p.row = drow[DIM_W-1:0];
			p.rgb = rgb;
			pending.push_back(p);
		endfunction

		function void check_pixel(logic [DIM_W-1:0] col, logic [DIM_W-1:0] row,
				logic [RGB_W-1:0] rgb);
			dst_pixel_t p;
			if (pending.size() == 0) begin
				$error("unexpected output transaction col=%0d row=%0d", col, row);
				fails++;
				return;
			end
			p = pending.pop_front();
			if (col !== p.col) begin
				$error("dst_col expected %0d actual %0d", p.col, col);
				fails++;
			end
			if (row !== p.row) begin
				$error("dst_row expected %0d actual %0d", p.row, row);
				fails++;
			end
			if (rgb !== p.rgb) begin
				$error("out_rgb expected %h actual %h", p.rgb, rgb);
				fails++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [FOC_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [CRD_W-1:0] src_col;
	logic [CRD_W-1:0] src_row;
	logic [RGB_W-1:0] pixel_rgb;
	logic             out_valid;
	logic             out_ready;
	logic [DIM_W-1:0] dst_col;
	logic [DIM_W-1:0] dst_row;
	logic [RGB_W-1:0] out_rgb;

	warp_scoreboard warp_sb;

	spherical_warp_coordinate_map_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.src_col   (src_col),
		.src_row   (src_row),
		.pixel_rgb (pixel_rgb),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dst_col   (dst_col),
		.dst_row   (dst_row),
		.out_rgb   (out_rgb)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// gap length: mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender side: one pixel transaction, valid held until accepted
	task automatic send_pixel(logic [CRD_W-1:0] col, logic [CRD_W-1:0] row,
			logic [RGB_W-1:0] rgb, int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		src_col   <= col;
		src_row   <= row;
		pixel_rgb <= rgb;
		do @(posedge clk); while (!in_ready);
		warp_sb.note_pixel(col, row, rgb);
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (warp_sb.pending.size() != 0) @(posedge clk);
		// a dropped pixel may still be in flight
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[FOC_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		warp_sb.set_reg(idx, data[FOC_W-1:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h, int unsigned f);
		go_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_FOCAL, f);
	endtask

	// random pixels, mostly inside the source image
	task automatic random_pixels(int unsigned count);
		longint w, h;
		logic [CRD_W-1:0] col, row;
		w = (warp_sb.img_w > 4096) ? 4096 : warp_sb.img_w;
		h = (warp_sb.img_h > 4096) ? 4096 : warp_sb.img_h;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 80 && w > 0 && h > 0) begin
				col = CRD_W'($urandom_range(0, int'(w) - 1));
				row = CRD_W'($urandom_range(0, int'(h) - 1));
			end else begin
				col = CRD_W'($urandom);
				row = CRD_W'($urandom);
			end
			send_pixel(col, row, RGB_W'($urandom), pick_gap());
			// once, hold off until every expected pixel has come out
			if (n == count / 2 && count > 100) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (warp_sb.pending.size() != 0) @(posedge clk);
			end
		end
	endtask

	// receiver side: random backpressure
	initial begin
		int unsigned g;
		out_ready = 1'b0;
		forever begin
			g = pick_gap();
			@(negedge clk);
			out_ready <= (g == 0);
			repeat (g) @(negedge clk);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			warp_sb.check_pixel(dst_col, dst_row, out_rgb);
	end

	// main sequence
	initial begin
		warp_sb   = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		src_col   = '0;
		src_row   = '0;
		pixel_rgb = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset geometry, corners, centre, field extremes
		send_pixel(12'd0, 12'd0, 24'h000000, 0);
		send_pixel(12'd320, 12'd240, 24'hffffff, 0);
		send_pixel(12'd639, 12'd479, 24'h5a5a5a, 0);
		send_pixel(12'd320, 12'd0, 24'ha5a5a5, 1);
		send_pixel(12'd0, 12'd240, 24'h0000ff, 0);
		send_pixel(12'd4095, 12'd4095, 24'hff0000, 0);
		send_pixel(12'd4095, 12'd240, 24'h00ff00, 2);
		send_pixel(12'd700, 12'd600, 24'h123456, 0);

		// unused register index has no effect
		go_idle();
		write_reg(REG_NONE, 32'h3fff);
		send_pixel(12'd100, 12'd100, 24'h654321, 0);

		// zero size and zero focal
		set_geometry(0, 0, 0);
		send_pixel(12'd0, 12'd0, 24'h010203, 0);
		send_pixel(12'd50, 12'd0, 24'h040506, 0);
		send_pixel(12'd4095, 12'd4095, 24'h070809, 0);

		// oversized image registers are clamped
		set_geometry(8191, 8191, 16383);
		send_pixel(12'd2048, 12'd2048, 24'habcdef, 0);
		send_pixel(12'd0, 12'd0, 24'hfedcba, 0);
		send_pixel(12'd4095, 12'd4095, 24'h0f0f0f, 0);

		// smallest image and focal
		set_geometry(1, 1, 1);
		send_pixel(12'd0, 12'd0, 24'hf0f0f0, 0);
		send_pixel(12'd4095, 12'd0, 24'h111111, 0);
		send_pixel(12'd0, 12'd4095, 24'h222222, 0);

		// random phases over a spread of geometries
		set_geometry(640, 480, 700);
		random_pixels(180);
		set_geometry(4096, 4096, 16383);
		random_pixels(170);
		set_geometry(64, 48, 50);
		random_pixels(170);
		set_geometry(1, 1, 1);
		random_pixels(120);
		set_geometry(320, 240, 300);
		random_pixels(170);
		set_geometry(4096, 16, 2000);
		random_pixels(150);
		set_geometry(2000, 3000, 16383);
		random_pixels(170);
		set_geometry(8191, 100, 1);
		random_pixels(120);
		set_geometry(0, 0, 0);
		random_pixels(60);
		for (int k = 0; k < 3; k++) begin
			set_geometry($urandom_range(1, 8191), $urandom_range(1, 8191),
				$urandom_range(1, 16383));
			random_pixels(80);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (warp_sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (warp_sb.fails == 0)
			$display("[spherical_warp_coordinate_map_unit] OK");
		else
			$display("[spherical_warp_coordinate_map_unit] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("[spherical_warp_coordinate_map_unit] ERROR");
		$finish;
	end

endmodule

// ===== spherical_warp_coordinate_map_unit.f =====
rtl/swc_pkg.sv
rtl/swc_vec_cell.sv
rtl/swc_rot_cell.sv
rtl/spherical_warp_coordinate_map_unit.sv
tb/spherical_warp_coordinate_map_unit_tb.sv
